### sv/spd_pkg.sv
// ============================================================================
// spd_pkg
// Shared types and constants for the settings profile decoder.
// ============================================================================
package spd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CAP_W  = 25;
    localparam int unsigned LEN_W  = 24;

    localparam logic [CAP_W-1:0] CAP_RESET = 25'd65536;
    localparam logic [CAP_W-1:0] CAP_LIMIT = 25'd16777216;

    // first byte at which the scrambled form stops inverting
    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'hfd;
    localparam logic [BYTE_W-1:0] INV_BASE = 8'hff;

    // header magic, one byte per header index 0..3
    localparam logic [BYTE_W-1:0] MAGIC_OLD [4] = '{8'h48, 8'h44, 8'h52, 8'h31};
    localparam logic [BYTE_W-1:0] MAGIC_NEW [4] = '{8'h48, 8'h44, 8'h52, 8'h32};

    localparam logic [2:0] HDR_LEN0 = 3'd4;
    localparam logic [2:0] HDR_LEN1 = 3'd5;
    localparam logic [2:0] HDR_LEN2 = 3'd6;
    localparam logic [2:0] HDR_SEED = 3'd7;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_SKIP   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_HEADER  = 2'd0,
        ST_DATA    = 2'd1,
        ST_INVALID = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] file_byte;
        logic              end_of_file;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        status_t           status;
        logic              body_last;
    } result_t;

endpackage

### sv/settings_profile_decoder.sv
// ============================================================================
// settings_profile_decoder
// Parses a settings profile byte stream: header check, body descramble,
// one status result per input byte.
// ============================================================================
//  channel | dir | payload
//  --------+-----+-------------------------------------------------------
//  s_*     | in  | tdata[7:0] file_byte, tlast end_of_file
//  m_*     | out | tdata[7:0] out_byte, tuser[1:0] status, tlast body_last
//  cfg_*   | in  | cfg_wr_data[24:0] capacity, written when cfg_wr_en
//
//  One byte per cycle sustained while m_tready is high; each byte passes the
//  input register, then is decoded into the result register.
//  Parser state advances when a byte moves from the input register into the
//  result register; stalls on m_tready back up through both registers.
//  rst_n clears the parser to header parsing and capacity to 65536.
// ============================================================================
module settings_profile_decoder
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,     // [7:0] file_byte
    input  logic                          s_tlast,     // end_of_file

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,     // [7:0] out_byte
    output logic [1:0]                    m_tuser,     // [1:0] status
    output logic                          m_tlast,     // body_last

    input  logic                          cfg_wr_en,
    input  logic [spd_pkg::CAP_W-1:0]     cfg_wr_data
);

    logic                             in_valid_reg, in_valid_next;
    spd_pkg::item_t                   in_item_reg, in_item_next;
    logic                             out_valid_reg, out_valid_next;
    spd_pkg::result_t                 out_res_reg, out_res_next;
    logic [spd_pkg::CAP_W-1:0]        cap_reg, cap_next;

    logic                             out_ready;
    logic                             advance;
    spd_pkg::result_t                 dec_res;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    spd_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (in_item_reg),
        .capacity (cap_reg),
        .result   (dec_res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        cap_next       = cfg_wr_en ? cfg_wr_data : cap_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            if (s_tvalid)
            begin
                in_item_next.file_byte   = s_tdata;
                in_item_next.end_of_file = s_tlast;
            end
        end
        if (out_ready)
        begin
            out_valid_next = in_valid_reg;
            if (advance)
            begin
                out_res_next = dec_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= spd_pkg::CAP_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cap_reg       <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.out_byte;
    assign m_tuser  = out_res_reg.status;
    assign m_tlast  = out_res_reg.body_last;

`ifndef SYNTHESIS
    a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.body_last) |-> (out_res_reg.status == spd_pkg::ST_DATA))
        else $error("body_last on a non-data result");

    a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.status != spd_pkg::ST_DATA))
            |-> (out_res_reg.out_byte == '0))
        else $error("nonzero byte on a non-data result");

    a_in_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_ready) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input register lost a byte under stall");
`endif

endmodule

### sv/spd_core.sv
// ============================================================================
// spd_core
// Parser state and per-byte decode: header fields, body descramble, status.
// ============================================================================
module spd_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  spd_pkg::item_t                item,
    input  logic [spd_pkg::CAP_W-1:0]     capacity,
    output spd_pkg::result_t              result
);

    spd_pkg::phase_t                  phase_reg, phase_next;
    logic [2:0]                       hdr_idx_reg, hdr_idx_next;
    logic                             ok_old_reg, ok_old_next;
    logic                             ok_new_reg, ok_new_next;
    logic [spd_pkg::LEN_W-1:0]        body_len_reg, body_len_next;
    logic [spd_pkg::BYTE_W-1:0]       seed_reg, seed_next;
    logic [spd_pkg::LEN_W-1:0]        body_cnt_reg, body_cnt_next;
    logic                             prev_nz_reg, prev_nz_next;

    logic [spd_pkg::BYTE_W-1:0]       b;
    logic                             eof;
    logic [spd_pkg::CAP_W-1:0]        cap_eff;
    logic                             len_ok;
    logic                             hdr_ok;
    logic                             at_seed;
    logic [spd_pkg::BYTE_W-1:0]       dec_byte;
    logic [spd_pkg::LEN_W-1:0]        cnt_inc;
    logic                             body_hit;

    assign b   = item.file_byte;
    assign eof = item.end_of_file;

    assign cap_eff = (capacity > spd_pkg::CAP_LIMIT) ? spd_pkg::CAP_LIMIT : capacity;
    assign at_seed = (hdr_idx_reg == spd_pkg::HDR_SEED);

    // old format: top length byte arrives with the seed slot; nonzero means >= 2^24
    assign len_ok = (ok_new_reg || (b == '0)) && (body_len_reg != '0)
                    && ({1'b0, body_len_reg} < cap_eff);
    assign hdr_ok = (ok_old_reg || ok_new_reg) && len_ok;

    always_comb
    begin
        dec_byte = b;
        if (ok_new_reg)
        begin
            if (b >= spd_pkg::ESC_BYTE)
            begin
                if ((body_cnt_reg != '0) && prev_nz_reg)
                begin
                    dec_byte = '0;
                end
            end
            else
            begin
                dec_byte = spd_pkg::INV_BASE + seed_reg - b;
            end
        end
    end

    assign cnt_inc  = body_cnt_reg + 1'b1;
    assign body_hit = (cnt_inc == body_len_reg);

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        ok_old_next   = ok_old_reg;
        ok_new_next   = ok_new_reg;
        body_len_next = body_len_reg;
        seed_next     = seed_reg;
        body_cnt_next = body_cnt_reg;
        prev_nz_next  = prev_nz_reg;
        if (advance)
        begin
            case (phase_reg)
                spd_pkg::PH_HEADER:
                begin
                    case (hdr_idx_reg)
                        spd_pkg::HDR_LEN0: body_len_next = {16'd0, b};
                        spd_pkg::HDR_LEN1: body_len_next[15:8] = b;
                        spd_pkg::HDR_LEN2: body_len_next[23:16] = b;
                        spd_pkg::HDR_SEED: seed_next = b;
                        default:
                        begin
                            if (b != spd_pkg::MAGIC_OLD[hdr_idx_reg[1:0]])
                            begin
                                ok_old_next = 1'b0;
                            end
                            if (b != spd_pkg::MAGIC_NEW[hdr_idx_reg[1:0]])
                            begin
                                ok_new_next = 1'b0;
                            end
                        end
                    endcase
                    if (at_seed)
                    begin
                        hdr_idx_next = '0;
                        if (eof)
                        begin
                            ok_old_next = 1'b1;
                            ok_new_next = 1'b1;
                        end
                        else if (!hdr_ok)
                        begin
                            phase_next = spd_pkg::PH_SKIP;
                        end
                        else
                        begin
                            phase_next    = spd_pkg::PH_BODY;
                            body_cnt_next = '0;
                            prev_nz_next  = 1'b0;
                        end
                    end
                    else if (eof)
                    begin
                        hdr_idx_next = '0;
                        ok_old_next  = 1'b1;
                        ok_new_next  = 1'b1;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 1'b1;
                    end
                end
                spd_pkg::PH_BODY:
                begin
                    prev_nz_next  = (dec_byte != '0);
                    body_cnt_next = cnt_inc;
                    if (eof)
                    begin
                        phase_next   = spd_pkg::PH_HEADER;
                        hdr_idx_next = '0;
                        ok_old_next  = 1'b1;
                        ok_new_next  = 1'b1;
                    end
                    else if (body_hit)
                    begin
                        phase_next = spd_pkg::PH_SKIP;
                    end
                end
                default:
                begin
                    if (eof)
                    begin
                        phase_next   = spd_pkg::PH_HEADER;
                        hdr_idx_next = '0;
                        ok_old_next  = 1'b1;
                        ok_new_next  = 1'b1;
                    end
                end
            endcase
        end
    end

    // result for the byte being decoded
    always_comb
    begin
        result.out_byte  = '0;
        result.status    = spd_pkg::ST_IGNORED;
        result.body_last = 1'b0;
        case (phase_reg)
            spd_pkg::PH_HEADER:
            begin
                if (eof || (at_seed && !hdr_ok))
                begin
                    result.status = spd_pkg::ST_INVALID;
                end
                else
                begin
                    result.status = spd_pkg::ST_HEADER;
                end
            end
            spd_pkg::PH_BODY:
            begin
                if (body_hit || !eof)
                begin
                    result.status    = spd_pkg::ST_DATA;
                    result.out_byte  = dec_byte;
                    result.body_last = body_hit;
                end
                else
                begin
                    result.status = spd_pkg::ST_INVALID;
                end
            end
            default:
            begin
                result.status = spd_pkg::ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= spd_pkg::PH_HEADER;
            hdr_idx_reg  <= '0;
            ok_old_reg   <= 1'b1;
            ok_new_reg   <= 1'b1;
            body_len_reg <= '0;
            seed_reg     <= '0;
            body_cnt_reg <= '0;
            prev_nz_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            ok_old_reg   <= ok_old_next;
            ok_new_reg   <= ok_new_next;
            body_len_reg <= body_len_next;
            seed_reg     <= seed_next;
            body_cnt_reg <= body_cnt_next;
            prev_nz_reg  <= prev_nz_next;
        end
    end

`ifndef SYNTHESIS
    a_body_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == spd_pkg::PH_BODY) |-> (body_len_reg != '0))
        else $error("body phase with zero length");

    a_body_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == spd_pkg::PH_BODY) |-> (body_cnt_reg < body_len_reg))
        else $error("body count ran past length");

    a_body_one_format: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == spd_pkg::PH_BODY) |-> (ok_old_reg != ok_new_reg))
        else $error("body phase without exactly one magic match");
`endif

endmodule
